// ----- rtl/core/ichk_pkg.sv -----
// Package for the Internet checksum block with pseudo-header support.
// Holds shared constants, the pipeline control struct and the ones'-complement add.
// Used by every module and interface under rtl/core.
package ichk_pkg;

	localparam int BYTES_PER_ITEM = 8;
	localparam int LANES          = BYTES_PER_ITEM / 2;
	localparam int NB_W           = 4;
	localparam int DATA_W         = 64;
	localparam int WORD_W         = 16;
	localparam int MODE_W         = 2;
	localparam int CNT_W          = 32;

	// Lane words plus protocol, upper length half and lower length half.
	localparam int TAIL_WORDS     = 3;
	localparam int MERGE_IN       = LANES + TAIL_WORDS;
	localparam int MERGE_LEVELS   = $clog2(MERGE_IN);
	localparam int MERGE_PAD      = 1 << MERGE_LEVELS;

	localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_IPV4  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_IPV6  = 2'd2;

	localparam logic KIND_PAYLOAD = 1'b0;

	typedef struct packed {
		logic vld;
		logic last;
	} ctl_t;

	function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
	endfunction

endpackage

// ----- rtl/core/ichk_in_if.sv -----
// Input channel interface: one packet word per transaction.
// Depends on ichk_pkg for field widths.
interface ichk_in_if;
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic [ichk_pkg::DATA_W-1:0]     data;
	logic [ichk_pkg::NB_W-1:0]       valid_bytes;
	logic                            last;
	logic [7:0]                      protocol;

	modport source(output valid, kind, data, valid_bytes, last, protocol, input ready);
	modport sink(input valid, kind, data, valid_bytes, last, protocol, output ready);
endinterface

// ----- rtl/core/ichk_out_if.sv -----
// Output channel interface: one checksum per transaction.
// Depends on ichk_pkg for field widths.
interface ichk_out_if;
	logic                            valid;
	logic                            ready;
	logic [ichk_pkg::WORD_W-1:0]     checksum;

	modport source(output valid, checksum, input ready);
	modport sink(input valid, checksum, output ready);
endinterface

// ----- rtl/core/ichk_lane.sv -----
// One checksum lane: extracts a big-endian 16-bit word and zeroes invalid bytes.
// Depends on ichk_pkg.
module ichk_lane #(
	parameter int LANE_IDX = 0
) (
	input  logic [ichk_pkg::WORD_W-1:0] word_in,
	input  logic [ichk_pkg::NB_W-1:0]   nbytes,
	output logic [ichk_pkg::WORD_W-1:0] word_out
);
	localparam logic [ichk_pkg::NB_W:0] HI_POS = (ichk_pkg::NB_W + 1)'(2 * LANE_IDX);
	localparam logic [ichk_pkg::NB_W:0] LO_POS = (ichk_pkg::NB_W + 1)'(2 * LANE_IDX + 1);

	logic hi_ok;
	logic lo_ok;

	assign hi_ok = HI_POS < {1'b0, nbytes};
	assign lo_ok = LO_POS < {1'b0, nbytes};
	assign word_out = {word_in[15:8] & {8{hi_ok}}, word_in[7:0] & {8{lo_ok}}};
endmodule

// ----- rtl/core/ichk_merge.sv -----
// Registered ones'-complement adder tree that merges the lane words of one transaction.
// One tree level per pipeline stage; depends on ichk_pkg.
module ichk_merge (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               en,
	input  logic [ichk_pkg::MERGE_IN-1:0][ichk_pkg::WORD_W-1:0] words,
	input  ichk_pkg::ctl_t                                     ctl_in,
	output logic [ichk_pkg::WORD_W-1:0]                        sum,
	output ichk_pkg::ctl_t                                     ctl_out
);
	localparam int LV  = ichk_pkg::MERGE_LEVELS;
	localparam int PAD = ichk_pkg::MERGE_PAD;

	logic [PAD-1:0][ichk_pkg::WORD_W-1:0] leaf;
	logic [LV:1][PAD-1:0][ichk_pkg::WORD_W-1:0] tree_s;
	ichk_pkg::ctl_t ctl_s [LV:1];

	always_comb begin
		for (int j = 0; j < PAD; j++) begin
			leaf[j] = (j < ichk_pkg::MERGE_IN) ? words[j] : '0;
		end
	end

	for (genvar k = 1; k <= LV; k++) begin : g_lvl
		logic [PAD-1:0][ichk_pkg::WORD_W-1:0] prev;
		ichk_pkg::ctl_t prev_ctl;

		if (k == 1) begin : g_first
			assign prev     = leaf;
			assign prev_ctl = ctl_in;
		end else begin : g_next
			assign prev     = tree_s[k-1];
			assign prev_ctl = ctl_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < PAD; j++) begin
					if (j < (PAD >> k)) begin
						tree_s[k][j] <= ichk_pkg::ones_add(prev[2*j], prev[2*j+1]);
					end else begin
						tree_s[k][j] <= '0;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (en) begin
				ctl_s[k] <= prev_ctl;
			end
		end
	end

	assign sum     = tree_s[LV][0];
	assign ctl_out = ctl_s[LV];
endmodule

// ----- rtl/core/internet_checksum_pseudo_header.sv -----
// Top level of the Internet checksum engine with TCP/UDP pseudo-header support.
// Depends on ichk_pkg, ichk_in_if, ichk_out_if, ichk_lane and ichk_merge.
//
// The item channel carries one packet word of up to eight bytes per transaction,
// the first wire byte in the top bits. Address bytes (kind one) are summed but not
// counted; payload bytes are summed and counted into the length. A transaction with
// last set closes the packet: the pseudo-header selected by pseudo_mode is added and
// the inverted folded sum appears as one transaction on the result channel.
// The user must write pseudo_mode through cfg_we and cfg_wdata while the block is idle;
// the block does not enforce this. Throughput is one item per cycle while the pipeline
// does not halt, set by the 16-bit end-around-carry accumulator; four lanes and a
// three-level registered adder tree handle the words of an item, and the result is
// registered. Reset clears the mode, the length counter, the accumulator and all valid
// flags. While an unread result waits, items keep flowing; the pipeline halts only
// when the next packet's result would overwrite it.
module internet_checksum_pseudo_header (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ichk_pkg::MODE_W-1:0]   cfg_wdata,
	ichk_in_if.sink                       item,
	ichk_out_if.source                    result
);
	localparam int WW = ichk_pkg::WORD_W;

	logic [ichk_pkg::MODE_W-1:0] mode_q;
	logic [ichk_pkg::CNT_W-1:0]  cnt_q;
	logic [ichk_pkg::CNT_W-1:0]  cnt_sum;
	logic [ichk_pkg::NB_W-1:0]   nb;
	logic [WW-1:0]               acc_q;
	logic [WW-1:0]               acc_sum;
	logic [WW-1:0]               checksum_q;
	logic                        res_vld_q;
	logic                        adv;
	logic                        accept;

	logic [ichk_pkg::MERGE_IN-1:0][WW-1:0] words;
	logic [ichk_pkg::MERGE_IN-1:0][WW-1:0] words_s1;
	ichk_pkg::ctl_t                        ctl_s1;
	ichk_pkg::ctl_t                        m_ctl;
	logic [WW-1:0]                         m_sum;

	assign adv    = !(res_vld_q && !result.ready && m_ctl.vld && m_ctl.last);
	assign accept = item.valid && adv;
	assign item.ready = adv;

	assign nb = (item.valid_bytes > ichk_pkg::NB_W'(ichk_pkg::BYTES_PER_ITEM))
		? ichk_pkg::NB_W'(ichk_pkg::BYTES_PER_ITEM) : item.valid_bytes;
	assign cnt_sum = cnt_q + ((item.kind == ichk_pkg::KIND_PAYLOAD)
		? ichk_pkg::CNT_W'(nb) : '0);

	for (genvar i = 0; i < ichk_pkg::LANES; i++) begin : g_lane
		ichk_lane #(
			.LANE_IDX(i)
		) u_lane (
			.word_in (item.data[ichk_pkg::DATA_W-1-WW*i -: WW]),
			.nbytes  (nb),
			.word_out(words[i])
		);
	end

	always_comb begin
		words[ichk_pkg::LANES]     = '0;
		words[ichk_pkg::LANES + 1] = '0;
		words[ichk_pkg::LANES + 2] = '0;
		if (item.last) begin
			case (mode_q)
				ichk_pkg::MODE_IPV4: begin
					words[ichk_pkg::LANES]     = {8'd0, item.protocol};
					words[ichk_pkg::LANES + 2] = cnt_sum[WW-1:0];
				end
				ichk_pkg::MODE_IPV6: begin
					words[ichk_pkg::LANES]     = {8'd0, item.protocol};
					words[ichk_pkg::LANES + 1] = cnt_sum[ichk_pkg::CNT_W-1:WW];
					words[ichk_pkg::LANES + 2] = cnt_sum[WW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ichk_pkg::MODE_PLAIN;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.vld  <= item.valid;
			ctl_s1.last <= item.last;
			if (item.valid) begin
				cnt_q <= item.last ? '0 : cnt_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			words_s1 <= words;
		end
	end

	ichk_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.words  (words_s1),
		.ctl_in (ctl_s1),
		.sum    (m_sum),
		.ctl_out(m_ctl)
	);

	assign acc_sum = ichk_pkg::ones_add(acc_q, m_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (adv && m_ctl.vld) begin
				acc_q <= m_ctl.last ? '0 : acc_sum;
			end
			if (adv && m_ctl.vld && m_ctl.last) begin
				res_vld_q <= 1'b1;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && m_ctl.vld && m_ctl.last) begin
			checksum_q <= ~acc_sum;
		end
	end

	assign result.valid    = res_vld_q;
	assign result.checksum = checksum_q;

	a_cnt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && item.last |=> cnt_q == '0)
		else $error("Length counter not cleared after the last transaction.");

	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && m_ctl.vld && m_ctl.last |=> acc_q == '0)
		else $error("Accumulator not cleared after a packet closed.");

	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_q) |-> $past(m_ctl.vld && m_ctl.last))
		else $error("Result raised without a closing transaction in the pipeline.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> res_vld_q && !result.ready)
		else $error("Input stalled while the result register could accept.");
endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for internet_checksum_pseudo_header.
// Drives packet words and mode writes, predicts each checksum and compares results in order.
// Depends on ichk_pkg, ichk_in_if, ichk_out_if and the RTL under rtl/core.
module testbench;

	localparam logic KIND_ADDRESS = 1'b1;
	localparam logic [ichk_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int LONG_WORDS = 100;
	localparam int RANDOM_ITEMS = 1680;

	class checksum_scoreboard;
		logic [ichk_pkg::MODE_W-1:0] mode;
		bit [31:0] sum_acc;
		bit [31:0] byte_count;
		bit [15:0] checksum_q[$];
		int errors;

		function new();
			mode = ichk_pkg::MODE_PLAIN;
			sum_acc = 0;
			byte_count = 0;
			errors = 0;
		endfunction

		function bit [31:0] carry_add(bit [31:0] s, bit [31:0] v);
			bit [32:0] r;
			r = {1'b0, s} + {1'b0, v};
			return r[31:0] + {31'd0, r[32]};
		endfunction

		function void accept_word(logic kind, logic [63:0] data, logic [3:0] nbytes_in,
			logic last, logic [7:0] proto);
			int n;
			int i;
			bit [31:0] folded;
			n = (nbytes_in > 4'd8) ? 8 : int'(nbytes_in);
			for (i = 0; i + 1 < n; i += 2)
				sum_acc = carry_add(sum_acc, {16'h0000, data[63-8*i -: 16]});
			if (i < n)
				sum_acc = carry_add(sum_acc, {16'h0000, data[63-8*i -: 8], 8'h00});
			if (kind == ichk_pkg::KIND_PAYLOAD)
				byte_count += n;
			if (!last)
				return;
			case (mode)
				ichk_pkg::MODE_IPV4: begin
					sum_acc = carry_add(sum_acc, {24'd0, proto});
					sum_acc = carry_add(sum_acc, {16'd0, byte_count[15:0]});
				end
				ichk_pkg::MODE_IPV6: begin
					sum_acc = carry_add(sum_acc, {24'd0, proto});
					sum_acc = carry_add(sum_acc, {16'd0, byte_count[31:16]});
					sum_acc = carry_add(sum_acc, {16'd0, byte_count[15:0]});
				end
				default: begin
				end
			endcase
			folded = sum_acc;
			while (folded[31:16] != 0)
				folded = {16'd0, folded[15:0]} + {16'd0, folded[31:16]};
			checksum_q.push_back(~folded[15:0]);
			sum_acc = 0;
			byte_count = 0;
		endfunction

		task report(string msg);
			$display("checksum mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_checksum(logic [15:0] got);
			bit [15:0] want;
			if (checksum_q.size() == 0) begin
				report($sformatf("unexpected result transaction, checksum %h", got));
				return;
			end
			want = checksum_q.pop_front();
			if (got !== want)
				report($sformatf("checksum %h, expected %h", got, want));
		endtask

		function int pending();
			return checksum_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ichk_pkg::MODE_W-1:0] cfg_wdata;

	ichk_in_if item_ch();
	ichk_out_if res_ch();

	checksum_scoreboard sb = new();

	int burst_left;
	int items_sent;

	internet_checksum_pseudo_header dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item(item_ch),
		.result(res_ch)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				sb.accept_word(item_ch.kind, item_ch.data, item_ch.valid_bytes,
					item_ch.last, item_ch.protocol);
			if (res_ch.valid && res_ch.ready)
				sb.check_checksum(res_ch.checksum);
		end
	end

	// The receiver switches at random between four stall styles.
	initial begin : receiver
		int stall_style;
		int stall_left;
		stall_style = 0;
		stall_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				res_ch.ready <= 1'b0;
			end else begin
				if (stall_left == 0) begin
					stall_style = $urandom_range(0, 3);
					stall_left = $urandom_range(16, 96);
				end
				stall_left--;
				case (stall_style)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= 1'($urandom_range(0, 1));
					2: res_ch.ready <= ($urandom_range(0, 7) == 0);
					default: res_ch.ready <= (stall_left % 3 != 0);
				endcase
			end
		end
	end

	function automatic logic [63:0] pick_data();
		case ($urandom_range(0, 9))
			0: return 64'hFFFF_FFFF_FFFF_FFFF;
			1: return 64'h0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_item(logic kind, logic [63:0] data, logic [3:0] nbytes,
		logic last, logic [7:0] proto);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_ch.valid <= 1'b1;
		item_ch.kind <= kind;
		item_ch.data <= data;
		item_ch.valid_bytes <= nbytes;
		item_ch.last <= last;
		item_ch.protocol <= proto;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
	endtask

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(logic [ichk_pkg::MODE_W-1:0] m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.mode = m;
	endtask

	task automatic send_random_packet();
		int n_addr;
		int n_pay;
		int k;
		if ($urandom_range(0, 99) < 85) begin
			case (sb.mode)
				ichk_pkg::MODE_IPV4: n_addr = 2;
				ichk_pkg::MODE_IPV6: n_addr = 4;
				default: n_addr = ($urandom_range(0, 3) == 0) ? 2 : 0;
			endcase
			n_pay = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
			for (k = 0; k < n_addr; k++)
				send_item(KIND_ADDRESS, pick_data(), 4'd8, 1'b0, 8'($urandom_range(0, 255)));
			for (k = 0; k < n_pay; k++)
				send_item(ichk_pkg::KIND_PAYLOAD, pick_data(), 4'd8, 1'b0,
					8'($urandom_range(0, 255)));
			send_item(ichk_pkg::KIND_PAYLOAD, pick_data(), 4'($urandom_range(1, 8)), 1'b1,
				8'($urandom_range(0, 255)));
		end else begin
			n_pay = $urandom_range(0, 5);
			for (k = 0; k < n_pay; k++)
				send_item(1'($urandom_range(0, 1)), pick_data(), 4'($urandom_range(0, 15)),
					1'b0, 8'($urandom_range(0, 255)));
			send_item(1'($urandom_range(0, 1)), pick_data(), 4'($urandom_range(0, 15)),
				1'b1, 8'($urandom_range(0, 255)));
		end
	endtask

	// A longer packet, so the upper byte of the length is exercised as well.
	task automatic send_long_packet();
		int k;
		for (k = 0; k < LONG_WORDS; k++)
			send_item(ichk_pkg::KIND_PAYLOAD, pick_data(), 4'd8, 1'b0, 8'h00);
		send_item(ichk_pkg::KIND_PAYLOAD, pick_data(), 4'd3, 1'b1, 8'h11);
	endtask

	initial begin : stimulus
		logic [ichk_pkg::MODE_W-1:0] phase_modes[8];
		int p;
		int goal;
		phase_modes = '{ichk_pkg::MODE_IPV4, ichk_pkg::MODE_PLAIN, ichk_pkg::MODE_IPV6,
			MODE_UNUSED, ichk_pkg::MODE_IPV6, ichk_pkg::MODE_IPV4, ichk_pkg::MODE_PLAIN,
			ichk_pkg::MODE_IPV6};
		burst_left = 0;
		items_sent = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.kind = 1'b0;
		item_ch.data = '0;
		item_ch.valid_bytes = '0;
		item_ch.last = 1'b0;
		item_ch.protocol = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_mode(ichk_pkg::MODE_PLAIN);
		send_item(ichk_pkg::KIND_PAYLOAD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 8'hFF);
		send_item(ichk_pkg::KIND_PAYLOAD, 64'h0, 4'd8, 1'b1, 8'h00);
		send_item(ichk_pkg::KIND_PAYLOAD, pick_data(), 4'd0, 1'b1, 8'h11);
		send_item(KIND_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 8'h80);
		send_item(ichk_pkg::KIND_PAYLOAD, 64'hA5C3_0F1E_7788_9911, 4'd3, 1'b0, 8'h00);
		send_item(ichk_pkg::KIND_PAYLOAD, 64'h1234_5678_9ABC_DEF0, 4'd5, 1'b1, 8'h00);
		wait_idle();
		write_mode(ichk_pkg::MODE_IPV4);
		send_item(KIND_ADDRESS, {$urandom, $urandom}, 4'd8, 1'b0, 8'h00);
		send_item(KIND_ADDRESS, {$urandom, $urandom}, 4'd8, 1'b0, 8'h00);
		send_item(ichk_pkg::KIND_PAYLOAD, {$urandom, $urandom}, 4'd5, 1'b1, 8'h06);
		send_item(ichk_pkg::KIND_PAYLOAD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1, 8'hFF);
		wait_idle();
		write_mode(ichk_pkg::MODE_IPV6);
		for (p = 0; p < 4; p++)
			send_item(KIND_ADDRESS, {$urandom, $urandom}, 4'd8, 1'b0, 8'h00);
		send_item(ichk_pkg::KIND_PAYLOAD, {$urandom, $urandom}, 4'd7, 1'b1, 8'h11);
		send_item(ichk_pkg::KIND_PAYLOAD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 1'b1, 8'h00);
		wait_idle();
		write_mode(MODE_UNUSED);
		send_item(ichk_pkg::KIND_PAYLOAD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 8'hFF);
		send_item(ichk_pkg::KIND_PAYLOAD, 64'h0123_4567_89AB_CDEF, 4'd2, 1'b1, 8'h06);

		for (p = 0; p < 8; p++) begin
			wait_idle();
			write_mode(phase_modes[p]);
			goal = items_sent + RANDOM_ITEMS / 8;
			while (items_sent < goal)
				send_random_packet();
		end

		wait_idle();
		write_mode(ichk_pkg::MODE_IPV4);
		send_long_packet();
		wait_idle();
		write_mode(ichk_pkg::MODE_IPV6);
		send_long_packet();

		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("[internet_checksum_pseudo_header] OK");
		else
			$display("[internet_checksum_pseudo_header] ERROR");
		$finish;
	end

	initial begin : watchdog
		#20000000;
		$display("[internet_checksum_pseudo_header] ERROR");
		$finish;
	end

endmodule
